### src/nmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmb_pkg: shared types and constants of the neighbour mean blur
// Image limits, field widths, item codes and the command and result records
// that travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package nmb_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int DCOL_W       = COL_W + 1;
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int PIX_W        = 8;
   localparam int SUM_W        = PIX_W + 3;
   localparam int LINE_W       = 2 * PIX_W;

   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_CFG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 4;

   // One classified item. For a pixel, col is x and col_l is x-1; for a drain
   // item, col_l, col and col_r are the clamped left, center and right columns.
   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] col_l;
      logic [COL_W-1:0] col_r;
      logic [ROW_W-1:0] row;
      logic             emit1;
      logic             emit2;
      logic             edge_l1;
      logic             x_zero;
      logic             top_same;
      logic             last;
   } nmb_cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } nmb_result_type;

endpackage
`default_nettype wire

### src/nmb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/nmb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmb_front: configuration, raster counters and item classification
// Accepts items, tracks the raster position and the drain column, drops
// items that do not fit the frame state and queues the rest as commands.
// ----------------------------------------------------------------------------
module nmb_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [nmb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [nmb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_type,
   input  wire logic [nmb_pkg::PIX_W-1:0]       req_pixel_in,
   input  wire logic                            queue_full,
   output logic                                 push,
   output nmb_pkg::nmb_cmd_type                 push_cmd
);
   import nmb_pkg::*;

   logic [WIDTH_CFG_W-1:0]  width_cfg_ff, width_cfg_in;
   logic [HEIGHT_CFG_W-1:0] height_cfg_ff, height_cfg_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [ROW_W-1:0]        in_row_ff, in_row_in;
   logic [DCOL_W-1:0]       drain_col_ff, drain_col_in;
   logic                    frame_done_ff, frame_done_in;

   logic [COL_W-1:0]        wlast;
   logic [ROW_W-1:0]        hlast;
   logic [COL_W-1:0]        x;
   logic [ROW_W-1:0]        y;
   logic [COL_W-1:0]        c;
   logic                    accept;
   logic                    is_drain;

   // Effective size, saturated into the legal range, kept as last index.
   always_comb begin
      if (width_cfg_ff == '0) begin
         wlast = '0;
      end else if (width_cfg_ff > WIDTH_CFG_W'(MAX_WIDTH)) begin
         wlast = COL_W'(MAX_WIDTH - 1);
      end else begin
         wlast = COL_W'(width_cfg_ff - WIDTH_CFG_W'(1));
      end
      if (height_cfg_ff == '0) begin
         hlast = '0;
      end else if (height_cfg_ff > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
         hlast = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hlast = ROW_W'(height_cfg_ff - HEIGHT_CFG_W'(1));
      end
   end

   always_comb begin
      x = (in_col_ff > wlast) ? wlast : in_col_ff;
      y = (in_row_ff > hlast) ? hlast : in_row_ff;
      c = (drain_col_ff > {1'b0, wlast}) ? wlast : drain_col_ff[COL_W-1:0];

      req_stall = queue_full;
      accept    = req_valid && !req_stall;
      is_drain  = (req_type == REQ_DRAIN);
      // Pixels count only before the frame is complete, drains only after it.
      push      = accept && (is_drain == frame_done_ff);

      push_cmd.pix = req_pixel_in;
      if (!is_drain) begin
         push_cmd.kind     = REQ_PIXEL;
         push_cmd.col      = x;
         push_cmd.col_l    = x - COL_W'(1);
         push_cmd.col_r    = x;
         push_cmd.row      = y - ROW_W'(1);
         push_cmd.emit1    = (y != '0) && (x != '0);
         push_cmd.emit2    = (y != '0) && (x == wlast);
         push_cmd.edge_l1  = (x == COL_W'(1));
         push_cmd.x_zero   = (x == '0);
         push_cmd.top_same = (y < ROW_W'(2));
         push_cmd.last     = 1'b0;
      end else begin
         push_cmd.kind     = REQ_DRAIN;
         push_cmd.col      = c;
         push_cmd.col_l    = (c == '0) ? c : c - COL_W'(1);
         push_cmd.col_r    = (c == wlast) ? c : c + COL_W'(1);
         push_cmd.row      = hlast;
         push_cmd.emit1    = 1'b0;
         push_cmd.emit2    = 1'b0;
         push_cmd.edge_l1  = 1'b0;
         push_cmd.x_zero   = 1'b0;
         push_cmd.top_same = (hlast == '0);
         push_cmd.last     = (c == wlast);
      end
   end

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      drain_col_in  = drain_col_ff;
      frame_done_in = frame_done_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_in  = csr_wdata[WIDTH_CFG_W-1:0];
            CSR_IMAGE_HEIGHT: height_cfg_in = csr_wdata[HEIGHT_CFG_W-1:0];
         endcase
      end

      if (push && !is_drain) begin
         if (x == wlast) begin
            in_col_in = '0;
            if (y == hlast) begin
               frame_done_in = 1'b1;
            end else begin
               in_row_in = y + ROW_W'(1);
            end
         end else begin
            in_col_in = x + COL_W'(1);
         end
      end

      if (push && is_drain) begin
         if (c == wlast) begin
            in_col_in     = '0;
            in_row_in     = '0;
            drain_col_in  = '0;
            frame_done_in = 1'b0;
         end else begin
            drain_col_in = {1'b0, c} + DCOL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_CFG_W'(1024);
         height_cfg_ff <= HEIGHT_CFG_W'(1024);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         drain_col_ff  <= '0;
         frame_done_ff <= 1'b0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         drain_col_ff  <= drain_col_in;
         frame_done_ff <= frame_done_in;
      end
   end

endmodule
`default_nettype wire

### src/nmb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmb_queue: command queue between front end and back end
// A small register FIFO so that either side may stall without the other.
// ----------------------------------------------------------------------------
module nmb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire nmb_pkg::nmb_cmd_type push_cmd,
   output logic                      full,
   input  wire logic                 pop,
   output nmb_pkg::nmb_cmd_type      pop_cmd,
   output logic                      not_empty
);
   import nmb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   nmb_cmd_type      entries_ff [QUEUE_DEPTH];
   nmb_cmd_type      entries_in [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + (push ? CNT_W'(1) : '0) - (pop ? CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### src/nmb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmb_back: line stores, window and neighbour sums
// Reads the line stores for a queued command, then forms the window, writes
// the stores back and pushes up to two results into the output FIFO.
// ----------------------------------------------------------------------------
module nmb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire nmb_pkg::nmb_cmd_type cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output nmb_pkg::nmb_result_type   rsp_result
);
   import nmb_pkg::*;

   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   function automatic logic [SUM_W-1:0] add8(
      input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1,
      input logic [PIX_W-1:0] p2, input logic [PIX_W-1:0] p3,
      input logic [PIX_W-1:0] p4, input logic [PIX_W-1:0] p5,
      input logic [PIX_W-1:0] p6, input logic [PIX_W-1:0] p7);
      return ((SUM_W'(p0) + SUM_W'(p1)) + (SUM_W'(p2) + SUM_W'(p3)))
           + ((SUM_W'(p4) + SUM_W'(p5)) + (SUM_W'(p6) + SUM_W'(p7)));
   endfunction

   // Read stage and compute stage.
   logic              a_take;
   logic              b_commit;
   logic              b_valid_ff, b_valid_in;
   nmb_cmd_type       b_cmd_ff;

   logic [COL_W-1:0]  rd_addr [3];
   logic [LINE_W-1:0] rd_data [3];
   logic [LINE_W-1:0] line [3];
   logic [2:0]        fwd_hit_ff, fwd_hit_in;
   logic [LINE_W-1:0] fwd_data_ff;

   logic              we;
   logic [LINE_W-1:0] wdata;

   // Window columns x-1 and x as left by the last pixel; rows top, mid, bottom.
   logic [PIX_W-1:0]  win1_ff [3];
   logic [PIX_W-1:0]  win2_ff [3];

   logic [PIX_W-1:0]  top_c [3];
   logic [PIX_W-1:0]  mid_c [3];
   logic [PIX_W-1:0]  bot_c [3];
   logic [PIX_W-1:0]  dtop [3];
   logic [PIX_W-1:0]  dmid [3];
   logic [SUM_W-1:0]  sum1, sum2, sumd;
   nmb_result_type    res1, res2, resd, first;
   logic [1:0]        n_res;

   nmb_result_type    oq_ff [OUT_DEPTH];
   nmb_result_type    oq_in [OUT_DEPTH];
   logic [OPTR_W-1:0] owr_ptr_ff, owr_ptr_in;
   logic [OPTR_W-1:0] ord_ptr_ff, ord_ptr_in;
   logic [OCNT_W-1:0] ocount_ff, ocount_in;
   logic              opop;

   // Room for two results lets any item commit without a partial push.
   assign b_commit = b_valid_ff && (ocount_ff <= OCNT_W'(OUT_DEPTH - 2));
   assign a_take   = cmd_valid && (!b_valid_ff || b_commit);
   assign cmd_pop  = a_take;

   always_comb begin
      rd_addr[0] = (cmd.kind == REQ_PIXEL) ? cmd.col : cmd.col_l;
      rd_addr[1] = cmd.col;
      rd_addr[2] = cmd.col_r;
   end

   // Each entry holds the two prior rows: older in the upper byte.
   assign we    = b_commit && (b_cmd_ff.kind == REQ_PIXEL);
   assign wdata = {line[0][PIX_W-1:0], b_cmd_ff.pix};

   nmb_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_ram0 (
      .clock(clock), .wr_en(we), .wr_addr(b_cmd_ff.col), .wr_data(wdata),
      .rd_en(a_take), .rd_addr(rd_addr[0]), .rd_data(rd_data[0]));
   nmb_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_ram1 (
      .clock(clock), .wr_en(we), .wr_addr(b_cmd_ff.col), .wr_data(wdata),
      .rd_en(a_take), .rd_addr(rd_addr[1]), .rd_data(rd_data[1]));
   nmb_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_ram2 (
      .clock(clock), .wr_en(we), .wr_addr(b_cmd_ff.col), .wr_data(wdata),
      .rd_en(a_take), .rd_addr(rd_addr[2]), .rd_data(rd_data[2]));

   // The item committing while the next one reads may hit the same entry;
   // its write data then replaces the stale read.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fwd_hit_in[k] = we && (b_cmd_ff.col == rd_addr[k]);
         line[k] = fwd_hit_ff[k] ? fwd_data_ff : rd_data[k];
      end
   end

   // Pixel window after the shift: columns x-2, x-1, x.
   always_comb begin
      top_c[0] = win1_ff[0];
      top_c[1] = win2_ff[0];
      top_c[2] = line[0][LINE_W-1:PIX_W];
      mid_c[0] = win1_ff[1];
      mid_c[1] = win2_ff[1];
      mid_c[2] = line[0][PIX_W-1:0];
      bot_c[0] = win1_ff[2];
      bot_c[1] = win2_ff[2];
      bot_c[2] = b_cmd_ff.pix;
      if (b_cmd_ff.top_same) begin
         top_c = mid_c;
      end

      sum1 = add8(b_cmd_ff.edge_l1 ? top_c[1] : top_c[0], top_c[1], top_c[2],
                  b_cmd_ff.edge_l1 ? mid_c[1] : mid_c[0], mid_c[2],
                  b_cmd_ff.edge_l1 ? bot_c[1] : bot_c[0], bot_c[1], bot_c[2]);
      sum2 = add8(b_cmd_ff.x_zero ? top_c[2] : top_c[1], top_c[2], top_c[2],
                  b_cmd_ff.x_zero ? mid_c[2] : mid_c[1], mid_c[2],
                  b_cmd_ff.x_zero ? bot_c[2] : bot_c[1], bot_c[2], bot_c[2]);

      // Drain: the last row is its own row below.
      for (int k = 0; k < 3; k++) begin
         dmid[k] = line[k][PIX_W-1:0];
         dtop[k] = b_cmd_ff.top_same ? line[k][PIX_W-1:0] : line[k][LINE_W-1:PIX_W];
      end
      sumd = add8(dtop[0], dtop[1], dtop[2], dmid[0], dmid[2],
                  dmid[0], dmid[1], dmid[2]);

      res1.pixel = sum1[SUM_W-1:3];
      res1.col   = b_cmd_ff.col_l;
      res1.row   = b_cmd_ff.row;
      res1.last  = 1'b0;
      res2.pixel = sum2[SUM_W-1:3];
      res2.col   = b_cmd_ff.col;
      res2.row   = b_cmd_ff.row;
      res2.last  = 1'b0;
      resd.pixel = sumd[SUM_W-1:3];
      resd.col   = b_cmd_ff.col;
      resd.row   = b_cmd_ff.row;
      resd.last  = b_cmd_ff.last;

      if (b_cmd_ff.kind == REQ_PIXEL) begin
         n_res = {1'b0, b_cmd_ff.emit1} + {1'b0, b_cmd_ff.emit2};
         first = b_cmd_ff.emit1 ? res1 : res2;
      end else begin
         n_res = 2'd1;
         first = resd;
      end
   end

   assign b_valid_in = a_take ? 1'b1 : (b_commit ? 1'b0 : b_valid_ff);

   // Output FIFO.
   assign opop       = (ocount_ff != '0) && !rsp_stall;
   assign rsp_valid  = (ocount_ff != '0);
   assign rsp_result = oq_ff[ord_ptr_ff];

   always_comb begin
      oq_in      = oq_ff;
      owr_ptr_in = owr_ptr_ff;
      ord_ptr_in = ord_ptr_ff;
      if (b_commit) begin
         if (n_res != 2'd0) begin
            oq_in[owr_ptr_ff] = first;
         end
         if (n_res == 2'd2) begin
            oq_in[owr_ptr_ff + OPTR_W'(1)] = res2;
         end
         owr_ptr_in = owr_ptr_ff + OPTR_W'(n_res);
      end
      if (opop) begin
         ord_ptr_in = ord_ptr_ff + OPTR_W'(1);
      end
      ocount_in = ocount_ff + (b_commit ? OCNT_W'(n_res) : '0)
                - (opop ? OCNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      oq_ff <= oq_in;
      if (a_take) begin
         b_cmd_ff    <= cmd;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= wdata;
      end
      if (reset) begin
         b_valid_ff <= 1'b0;
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocount_ff  <= '0;
         for (int k = 0; k < 3; k++) begin
            win1_ff[k] <= '0;
            win2_ff[k] <= '0;
         end
      end else begin
         b_valid_ff <= b_valid_in;
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocount_ff  <= ocount_in;
         if (we) begin
            for (int k = 0; k < 3; k++) begin
               win1_ff[k] <= win2_ff[k];
            end
            win2_ff[0] <= line[0][LINE_W-1:PIX_W];
            win2_ff[1] <= line[0][PIX_W-1:0];
            win2_ff[2] <= b_cmd_ff.pix;
         end
      end
   end

endmodule
`default_nettype wire

### src/neighbour_mean_blur_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// neighbour_mean_blur_3x3: streaming 3x3 blur without the center pixel
// Pixel items arrive in raster order on the req_ channel; after the frame,
// drain items (req_type high) deliver the last row, one result per item.
// Each result is the sum of the eight clamped neighbours divided by eight,
// with its column, row and a flag on the final pixel of the frame.
// The csr_ port sets image width and height; write it only while idle.
// Throughput is one item per cycle while req_stall is low. The item in
// the last column of a row after the first makes two results and the rsp_
// port moves one per cycle while rsp_stall is low. A result passes the
// command queue, the line store read and the compute stage, which writes
// it into the output FIFO. Three copies of the line store give the three
// column reads a drain item needs in a single cycle.
// Reset clears the counters, the queues and the window; the line stores hold
// no reset value and are filled by the first rows of a frame. While rsp_stall
// is high results wait in a four-entry output FIFO, then the command queue
// fills and req_stall rises.
// ----------------------------------------------------------------------------
module neighbour_mean_blur_3x3 (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [nmb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [nmb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_type,
   input  wire logic [nmb_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [nmb_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic      [nmb_pkg::COL_W-1:0]       rsp_out_col,
   output logic      [nmb_pkg::ROW_W-1:0]       rsp_out_row,
   output logic                                 rsp_frame_last
);
   import nmb_pkg::*;

   logic           push;
   nmb_cmd_type    push_cmd;
   logic           queue_full;
   logic           pop;
   nmb_cmd_type    pop_cmd;
   logic           not_empty;
   nmb_result_type result;

   nmb_front u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_pixel_in(req_pixel_in),
      .queue_full(queue_full), .push(push), .push_cmd(push_cmd));

   nmb_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(push_cmd), .full(queue_full),
      .pop(pop), .pop_cmd(pop_cmd), .not_empty(not_empty));

   nmb_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(not_empty), .cmd(pop_cmd), .cmd_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(result));

   assign rsp_pixel_out  = result.pixel;
   assign rsp_out_col    = result.col;
   assign rsp_out_row    = result.row;
   assign rsp_frame_last = result.last;

endmodule
`default_nettype wire
